[rtl/positional_list_engine_macros.svh]
// Assertion macros used by the positional list engine datapath.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Plain check, sampled on the rising clock edge, off while in reset.
`define PLE_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);
// Implication: whenever ante holds, cons must hold on the same edge.
`define PLE_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PLE_ASSERT(name, clk, rstn, prop, msg)
`define PLE_ASSERT_IMPL(name, clk, rstn, ante, cons, msg)
`endif

`endif

[rtl/ple_pkg.sv]
// Shared types and constants for the positional list engine.
package ple_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 7;
    localparam int CNT_W     = 7;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_READ      = 3'd0,
        OP_INS_FRONT = 3'd1,
        OP_INS_END   = 3'd2,
        OP_INS_POS   = 3'd3,
        OP_DEL_FRONT = 3'd4,
        OP_DEL_END   = 3'd5,
        OP_DEL_POS   = 3'd6,
        OP_CLEAR     = 3'd7
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CLS_READ = 2'd0,
        CLS_INS  = 2'd1,
        CLS_DEL  = 2'd2,
        CLS_CLR  = 2'd3
    } cls_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic fetch;
        logic keep;
        logic shift;
        logic finish;
        logic clear;
        logic rd_issue;
        logic rd_emit;
        logic reply;
    } ple_cmd_t;

    // datapath -> controller
    typedef struct packed {
        cls_t    cls;
        status_t status;
        logic    shift_done;
        logic    rd_last;
        logic    out_free;
    } ple_stat_t;

endpackage

[rtl/positional_list_engine.sv]
// Top level of the positional list engine: sequencer plus datapath.
//
// Ordered list of up to CAPACITY signed 32-bit values held in a single-port-write,
// registered-read memory. Each input beat is one command; every command returns
// one result beat with tlast set, except a readout of a nonempty list, which
// returns one beat per element, front first, tlast on the final one. Inserts and
// deletes move the entries behind the target slot one slot per cycle through the
// memory port, at most CAPACITY - 1 entries, and none at the end of the list.
// A readout streams one element per cycle while m_axis_tready stays high. A
// result beat that is not taken holds the sequencer until it is. Errors (empty
// list, bad position, store full) change nothing. The store needs no clearing
// after reset; entries past the count are never read.
// item_count carries the low 7 bits of the count.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // position[6:0], value[38:7]
    input  logic [OP_W-1:0]      s_axis_tuser,   // cmd[2:0]

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // item_value[31:0], item_count[38:32]
    output logic [ST_W-1:0]      m_axis_tuser,   // status[1:0]
    output logic                 m_axis_tlast
);

    ple_cmd_t  cmd;
    ple_stat_t stat;

    ple_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

endmodule

[rtl/ple_ctrl.sv]
// Command sequencer for the positional list engine.
module ple_ctrl
    import ple_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ple_stat_t stat,
    output ple_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECODE   = 7'b0000010,
        S_KEEP     = 7'b0000100,
        S_SHIFT    = 7'b0001000,
        S_REPLY    = 7'b0010000,
        S_RD_ISSUE = 7'b0100000,
        S_RD_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                if (stat.status != ST_OK) begin
                    state_next = S_REPLY;
                end else begin
                    case (stat.cls)
                        CLS_READ: state_next = S_RD_ISSUE;
                        CLS_INS:  state_next = S_SHIFT;
                        CLS_DEL: begin
                            // pull the victim out before the gap is closed
                            cmd.fetch  = 1'b1;
                            state_next = S_KEEP;
                        end
                        CLS_CLR: begin
                            cmd.clear  = 1'b1;
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end
            S_KEEP: begin
                cmd.keep   = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT: begin
                if (stat.shift_done) begin
                    cmd.finish = 1'b1;
                    state_next = S_REPLY;
                end else begin
                    cmd.shift = 1'b1;
                end
            end
            S_REPLY: begin
                if (stat.out_free) begin
                    cmd.reply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD_ISSUE: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                if (stat.out_free) begin
                    cmd.rd_emit = 1'b1;
                    if (stat.rd_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/ple_datapath.sv]
// List store, entry count, shift walker and result register.
`include "positional_list_engine_macros.svh"

module ple_datapath
    import ple_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ple_cmd_t             cmd,
    output ple_stat_t            stat,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [ST_W-1:0]      m_tuser,
    output logic                 m_tlast
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    op_t               op_reg, op_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     walk_reg, walk_next;
    logic [AW-1:0]     left_reg, left_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] outv_reg, outv_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] store_reg [CAPACITY];

    logic              m_valid_reg, m_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;
    logic              out_last_reg, out_last_next;

    logic [PW-1:0]     cnt_x, pos_x, tgt_x;
    logic [AW-1:0]     tgt, src_addr, rd_addr, wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              full, empty, ins_pos_ok, del_pos_ok;
    logic              rd_en, wr_en, rd_last, out_free;
    cls_t              cls;
    status_t           dec_status;

    // ---- command decode against the current count
    assign cnt_x      = PW'(count_reg);
    assign pos_x      = PW'(pos_reg);
    assign full       = (cnt_x >= PW'(CAPACITY));
    assign empty      = (count_reg == '0);
    assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + PW'(1));
    assign del_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);

    always_comb begin
        cls        = CLS_CLR;
        dec_status = ST_OK;
        tgt_x      = '0;
        unique case (op_reg) inside
            OP_READ: begin
                cls = CLS_READ;
                if (empty) dec_status = ST_EMPTY;
            end
            OP_INS_FRONT, OP_INS_END: begin
                cls = CLS_INS;
                if (full) dec_status = ST_FULL;
                if (op_reg == OP_INS_END) tgt_x = cnt_x;
            end
            OP_INS_POS: begin
                cls = CLS_INS;
                // position is checked ahead of room
                if (!ins_pos_ok) dec_status = ST_BADPOS;
                else if (full)   dec_status = ST_FULL;
                tgt_x = pos_x - PW'(1);
            end
            OP_DEL_FRONT, OP_DEL_END: begin
                cls = CLS_DEL;
                if (empty) dec_status = ST_EMPTY;
                if (op_reg == OP_DEL_END) tgt_x = cnt_x - PW'(1);
            end
            OP_DEL_POS: begin
                cls = CLS_DEL;
                if (empty)            dec_status = ST_EMPTY;
                else if (!del_pos_ok) dec_status = ST_BADPOS;
                tgt_x = pos_x - PW'(1);
            end
            OP_CLEAR: begin
                cls = CLS_CLR;
            end
        endcase
    end

    assign tgt      = tgt_x[AW-1:0];
    // insert walks down (reads walk-1), delete walks up (reads walk+1)
    assign src_addr = (cls == CLS_INS) ? walk_reg - AW'(1) : walk_reg + AW'(1);
    assign rd_last  = (PW'(walk_reg) == cnt_x - PW'(1));
    assign out_free = !m_valid_reg || m_tready;

    assign stat.cls        = cls;
    assign stat.status     = dec_status;
    assign stat.shift_done = (left_reg == '0) && !wr_pend_reg;
    assign stat.rd_last    = rd_last;
    assign stat.out_free   = out_free;

    // ---- memory port selection
    assign rd_en = cmd.fetch || (cmd.shift && (left_reg != '0)) || cmd.rd_issue ||
                   (cmd.rd_emit && !rd_last);

    always_comb begin
        if (cmd.fetch)         rd_addr = tgt;
        else if (cmd.shift)    rd_addr = src_addr;
        else if (cmd.rd_issue) rd_addr = walk_reg;
        else                   rd_addr = walk_reg + AW'(1);
    end

    // the closing write of an insert never meets a pending shift write
    assign wr_en   = (cmd.shift && wr_pend_reg) || (cmd.finish && (cls == CLS_INS));
    assign wr_addr = cmd.finish ? tgt : wr_addr_reg;
    assign wr_data = cmd.finish ? val_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) store_reg[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= store_reg[rd_addr];
    end

    // ---- next state
    always_comb begin
        op_next      = op_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        walk_next    = walk_reg;
        left_next    = left_reg;
        wr_pend_next = wr_pend_reg;
        wr_addr_next = wr_addr_reg;
        status_next  = status_reg;
        outv_next    = outv_reg;

        if (cmd.load) begin
            op_next  = op_t'(s_tuser);
            pos_next = s_tdata[POS_W-1:0];
            val_next = s_tdata[POS_W +: DATA_W];
        end
        if (cmd.decode) begin
            status_next  = dec_status;
            outv_next    = '0;
            wr_pend_next = 1'b0;
            case (cls)
                CLS_INS: begin
                    walk_next = cnt_x[AW-1:0];
                    left_next = AW'(cnt_x - tgt_x);
                end
                CLS_DEL: begin
                    walk_next = tgt;
                    left_next = AW'(cnt_x - tgt_x - PW'(1));
                end
                default: begin
                    walk_next = '0;
                    left_next = '0;
                end
            endcase
        end
        if (cmd.keep) outv_next = rd_data_reg;
        if (cmd.clear) count_next = '0;
        if (cmd.shift) begin
            wr_pend_next = (left_reg != '0);
            if (left_reg != '0) begin
                wr_addr_next = walk_reg;
                walk_next    = src_addr;
                left_next    = left_reg - AW'(1);
            end
        end
        if (cmd.finish) begin
            count_next = (cls == CLS_INS) ? count_reg + CW'(1) : count_reg - CW'(1);
        end
        if (cmd.rd_emit && !rd_last) walk_next = walk_reg + AW'(1);
    end

    // ---- result register
    always_comb begin
        m_valid_next    = m_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        if (cmd.reply) begin
            m_valid_next    = 1'b1;
            out_status_next = status_reg;
            out_value_next  = outv_reg;
            out_count_next  = cnt_x[CNT_W-1:0];
            out_last_next   = 1'b1;
        end else if (cmd.rd_emit) begin
            m_valid_next    = 1'b1;
            out_status_next = ST_OK;
            out_value_next  = rd_data_reg;
            out_count_next  = cnt_x[CNT_W-1:0];
            out_last_next   = rd_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        walk_reg       <= walk_next;
        left_reg       <= left_next;
        wr_addr_reg    <= wr_addr_next;
        status_reg     <= status_next;
        outv_reg       <= outv_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - CNT_W){1'b0}}, out_count_reg, out_value_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    `PLE_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `PLE_ASSERT_IMPL(a_count_step, aclk, aresetn, $past(aresetn) && (count_reg != $past(count_reg)), (count_reg == $past(count_reg) + CW'(1)) || (count_reg == $past(count_reg) - CW'(1)) || (count_reg == '0), "entry count moved by more than one")
    `PLE_ASSERT_IMPL(a_err_value_zero, aclk, aresetn, m_valid_reg && (out_status_reg != ST_OK), out_value_reg == '0, "error beat carries a nonzero value")
    `PLE_ASSERT_IMPL(a_place_no_pend, aclk, aresetn, cmd.finish, !wr_pend_reg, "closing write collides with a pending shift write")

endmodule
